// File: rtl/ms_pkg.sv
// ----------------------------------------------------------------------------
// ms_pkg: shared types and constants of the merge sorter
// Element width, the link carried between neighboring sort cells and the
// control word broadcast to every cell of the chain.
// ----------------------------------------------------------------------------
`default_nettype none

package ms_pkg;

  // Width of one element, two's complement.
  localparam int unsigned DataW = 32;

  // What one cell shows its neighbors.
  typedef struct packed {
    logic                    valid;   // cell holds an element
    logic                    ahead;   // incoming element sorts ahead of this cell
    logic signed [DataW-1:0] value;   // stored element
  } link_t;

  // Control word broadcast to all cells.
  typedef struct packed {
    logic insert;  // place the broadcast element into the sorted row
    logic shift;   // move every element one cell toward the output
  } ctrl_t;

endpackage

`default_nettype wire

// File: rtl/merge_sorter.sv
// ----------------------------------------------------------------------------
// merge_sorter: sorts a set of signed 32-bit elements ascending
// Elements enter on the slave stream, one per transfer; the transfer with
// tlast ends the set. Every kept element is placed into a row of MAX_ELEMS
// cells as it arrives, so the row is always sorted. After the last element the
// row shifts toward the master stream, one sorted element per transfer.
//
// Input channel: one element per cycle while loading. Elements beyond
// MAX_ELEMS are dropped; every result of that set then carries tuser = 1.
// Output channel: the first result is offered the cycle after the last input
// transfer, then one result per cycle while the receiver is ready; tlast marks
// the final one. While results drain, s_axis_tready is low; the next set may
// start the cycle after the final result transfer. A stalled receiver simply
// holds the row: cell 0 is the output register.
// Reset empties the row and clears the count and the drop flag; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module merge_sorter #(
  parameter int unsigned MAX_ELEMS = 64
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire [ms_pkg::DataW-1:0]        s_axis_tdata,   // [31:0] value
  input  wire                            s_axis_tlast,   // last_in
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  output logic [ms_pkg::DataW-1:0]       m_axis_tdata,   // [31:0] sorted_value
  output logic                           m_axis_tlast,   // last_out
  output logic                           m_axis_tuser    // overflow
);

  localparam int unsigned CntW = $clog2(MAX_ELEMS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_ELEMS);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  logic            drain_q, drain_d;
  logic [CntW-1:0] count_q, count_d;
  logic            drop_q, drop_d;
  logic            in_xfer, out_xfer, room;
  ms_pkg::ctrl_t   ctrl;

  ms_pkg::link_t   links [MAX_ELEMS];
  ms_pkg::link_t   edge_link;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign room     = (count_q < CntMax);

  // Broadcast control for the cell row.
  assign ctrl.insert = in_xfer && room;
  assign ctrl.shift  = out_xfer;

  // Empty boundary cell at both ends of the row.
  assign edge_link.valid = 1'b0;
  assign edge_link.ahead = 1'b0;
  assign edge_link.value = '0;

  // Load and drain bookkeeping.
  always_comb begin
    drain_d = drain_q;
    count_d = count_q;
    drop_d  = drop_q;
    if (!drain_q) begin
      if (in_xfer) begin
        if (room) begin
          count_d = count_q + CntOne;
        end else begin
          drop_d = 1'b1;
        end
        if (s_axis_tlast) begin
          drain_d = 1'b1;
        end
      end
    end else if (out_xfer) begin
      count_d = count_q - CntOne;
      if (count_q == CntOne) begin
        drain_d = 1'b0;
        drop_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q <= 1'b0;
      count_q <= '0;
      drop_q  <= 1'b0;
    end else begin
      drain_q <= drain_d;
      count_q <= count_d;
      drop_q  <= drop_d;
    end
  end

  // Row of sort cells; cell 0 faces the output.
  for (genvar i = 0; i < MAX_ELEMS; i++) begin : g_cell
    ms_pkg::link_t left_l, right_l;
    if (i == 0) begin : g_first
      assign left_l = edge_link;
    end else begin : g_mid_l
      assign left_l = links[i-1];
    end
    if (i == MAX_ELEMS - 1) begin : g_last
      assign right_l = edge_link;
    end else begin : g_mid_r
      assign right_l = links[i+1];
    end
    ms_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .elem_i  (s_axis_tdata),
      .left_i  (left_l),
      .right_i (right_l),
      .link_o  (links[i])
    );
  end

  // Stream ports.
  assign s_axis_tready = !drain_q;
  assign m_axis_tvalid = drain_q;
  assign m_axis_tdata  = links[0].value;
  assign m_axis_tlast  = (count_q == CntOne);
  assign m_axis_tuser  = drop_q;

endmodule

`default_nettype wire

// File: rtl/ms_cell.sv
// ----------------------------------------------------------------------------
// ms_cell: one cell of the sorting chain
// Holds one element. On insert it compares the broadcast element against its
// own and either keeps its value, takes the element, or takes the value of
// its left neighbor. On shift it takes the value of its right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module ms_cell (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire ms_pkg::ctrl_t                   ctrl_i,
  input  wire logic signed [ms_pkg::DataW-1:0] elem_i,
  input  wire ms_pkg::link_t                   left_i,
  input  wire ms_pkg::link_t                   right_i,
  output ms_pkg::link_t                        link_o
);

  logic                            valid_q, valid_d;
  logic signed [ms_pkg::DataW-1:0] value_q, value_d;
  logic                            ahead;

  // An empty cell counts as larger than anything. Strict compare keeps equal
  // elements in arrival order.
  assign ahead = !valid_q || (elem_i < value_q);

  // Next value of the cell.
  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (ctrl_i.insert && ahead) begin
      if (left_i.ahead) begin
        valid_d = left_i.valid;
        value_d = left_i.value;
      end else begin
        valid_d = 1'b1;
        value_d = elem_i;
      end
    end else if (ctrl_i.shift) begin
      valid_d = right_i.valid;
      value_d = right_i.value;
    end
  end

  // Occupancy bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Element register.
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign link_o.valid = valid_q;
  assign link_o.ahead = ahead;
  assign link_o.value = value_q;

endmodule

`default_nettype wire

// File: tb/sv/merge_sorter_checker.sv
// ----------------------------------------------------------------------------
// merge_sorter_checker: result predictor and scoreboard for the merge sorter
// Watches both stream channels. Every input transfer that fits is added to a
// set kept in ascending order. The transfer with tlast closes the set and
// queues its sorted results. Each output transfer is compared field by field
// with the oldest queued result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module merge_sorter_checker #(
  parameter int unsigned MAX_ELEMS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  input  logic                     s_axis_tready,
  input  logic [ms_pkg::DataW-1:0] s_axis_tdata,   // [31:0] value
  input  logic                     s_axis_tlast,   // last_in
  input  logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  input  logic [ms_pkg::DataW-1:0] m_axis_tdata,   // [31:0] sorted_value
  input  logic                     m_axis_tlast,   // last_out
  input  logic                     m_axis_tuser,   // overflow
  output int                       errors_o,
  output int                       pending_o
);

  typedef struct packed {
    logic signed [ms_pkg::DataW-1:0] value;
    logic                            last;
    logic                            overflow;
  } sorted_result_t;

  // The set being loaded, kept in ascending order at all times.
  logic signed [ms_pkg::DataW-1:0] set_sorted_q[$];
  logic                            set_dropped = 1'b0;
  sorted_result_t                  sorted_results_q[$];
  int                              mismatches = 0;

  // Adds one element to the set; the element marked last releases the set.
  function automatic void load_element(input logic signed [ms_pkg::DataW-1:0] value,
                                       input logic last);
    int             pos;
    sorted_result_t res;
    if (set_sorted_q.size() < MAX_ELEMS) begin
      // An equal element already loaded stays ahead of the new one.
      pos = set_sorted_q.size();
      while (pos > 0 && set_sorted_q[pos-1] > value) pos--;
      set_sorted_q.insert(pos, value);
    end else begin
      set_dropped = 1'b1;
    end
    if (last) begin
      foreach (set_sorted_q[k]) begin
        res.value    = set_sorted_q[k];
        res.last     = (k == set_sorted_q.size() - 1);
        res.overflow = set_dropped;
        sorted_results_q.push_back(res);
      end
      set_sorted_q.delete();
      set_dropped = 1'b0;
    end
  endfunction

  // Compares one received result with the oldest queued one.
  function automatic void check_result(input logic [ms_pkg::DataW-1:0] value,
                                       input logic last, input logic overflow);
    sorted_result_t exp_res;
    if (sorted_results_q.size() == 0) begin
      $error("result with nothing queued: sorted_value %0d", $signed(value));
      mismatches++;
      return;
    end
    exp_res = sorted_results_q.pop_front();
    if (value !== exp_res.value) begin
      $error("sorted_value: expected %0d, got %0d", exp_res.value, $signed(value));
      mismatches++;
    end
    if (last !== exp_res.last) begin
      $error("last_out: expected %0b, got %0b", exp_res.last, last);
      mismatches++;
    end
    if (overflow !== exp_res.overflow) begin
      $error("overflow: expected %0b, got %0b", exp_res.overflow, overflow);
      mismatches++;
    end
  endfunction

  // Sample both channels at every rising edge out of reset.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        load_element(s_axis_tdata, s_axis_tlast);
      end
      errors_o  <= mismatches;
      pending_o <= sorted_results_q.size();
    end
  end

endmodule

// File: tb/sv/merge_sorter_tb.sv
// ----------------------------------------------------------------------------
// merge_sorter_tb: stimulus and verdict for the merge sorter
// Sends directed sets with extreme and repeated values, a long receiver
// hold-off with full and overflowing sets, then random sets under several
// idle and stall mixes. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module merge_sorter_tb;

  localparam int unsigned Capacity  = 64;
  localparam int unsigned HoldOff   = 400;
  localparam int unsigned QuietMax  = 2000;
  localparam logic [ms_pkg::DataW-1:0] MinValue = 32'h8000_0000;
  localparam logic [ms_pkg::DataW-1:0] MaxValue = 32'h7FFF_FFFF;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [ms_pkg::DataW-1:0] s_axis_tdata  = '0;    // [31:0] value
  logic                     s_axis_tlast  = 1'b0;  // last_in
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [ms_pkg::DataW-1:0] m_axis_tdata;          // [31:0] sorted_value
  logic                     m_axis_tlast;          // last_out
  logic                     m_axis_tuser;          // overflow

  int          errors;
  int          pending;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  logic        hold_req        = 1'b0;
  int unsigned hold_left       = 0;
  logic        hold_armed      = 1'b1;

  merge_sorter #(
    .MAX_ELEMS(Capacity)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  merge_sorter_checker #(
    .MAX_ELEMS(Capacity)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  // Clock.
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Reset at the start of the run only.
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Receiver: random stalls, plus one long hold-off when requested.
  always @(posedge clk_i) begin
    if (hold_req && hold_armed) begin
      hold_left     <= HoldOff;
      hold_armed    <= 1'b0;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (!hold_req) hold_armed <= 1'b1;
    end
  end

  // Ends the run when no transfer happens for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietMax) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Offers one element, after a random gap, and waits for its transfer.
  task automatic send_element(input logic [ms_pkg::DataW-1:0] value, input logic last);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Extremes and small values are frequent so that repeats occur.
  function automatic logic [ms_pkg::DataW-1:0] pick_value();
    case ($urandom_range(9))
      0:       return MinValue;
      1:       return MaxValue;
      2, 3, 4: return $urandom_range(16) - 8;
      default: return $urandom();
    endcase
  endfunction

  // Sends a set of random elements; the final one carries tlast.
  task automatic send_set(input int unsigned count);
    for (int unsigned k = 1; k <= count; k++) send_element(pick_value(), k == count);
  endtask

  // Random sets under one idle/stall mix: mostly small, some larger up to full, some overflowing.
  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input int unsigned quota);
    int unsigned sent;
    int unsigned count;
    sent            = 0;
    sender_idle_pct = idle_pct;
    recv_stall_pct <= stall_pct;
    while (sent < quota) begin
      case ($urandom_range(19))
        0:       count = $urandom_range(Capacity + 4, Capacity + 1);
        1:       count = $urandom_range(Capacity, 13);
        default: count = $urandom_range(12, 1);
      endcase
      send_set(count);
      sent += count;
    end
  endtask

  // Stimulus and verdict.
  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);

    // Directed: a single element, extremes with repeats, a reversed pair.
    send_element(MaxValue, 1'b1);
    send_element(MinValue, 1'b0);
    send_element(MaxValue, 1'b0);
    send_element(32'd0, 1'b0);
    send_element(32'hFFFF_FFFF, 1'b0);
    send_element(MaxValue, 1'b0);
    send_element(MinValue, 1'b0);
    send_element(32'd1, 1'b1);
    send_element(32'd5, 1'b0);
    send_element(-32'sd5, 1'b1);

    // Let the directed sets drain so that the hold-off starts on an empty row.
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);

    // Receiver holds off while a full set and an overflowing set are offered.
    hold_req <= 1'b1;
    send_set(Capacity);
    send_set(Capacity + 2);
    hold_req <= 1'b0;

    // Random sets under each idle/stall mix.
    run_phase(0, 0, 40);
    run_phase(72, 0, 40);
    run_phase(0, 72, 40);
    run_phase(33, 33, 40);
    s_axis_tvalid <= 1'b0;

    // Drain, then allow for stray results.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (2 * Capacity + 16) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ms_pkg.sv
rtl/ms_cell.sv
rtl/merge_sorter.sv
tb/sv/merge_sorter_checker.sv
tb/sv/merge_sorter_tb.sv
